[design/btf_pkg.sv]
// shared types, codes and defaults for the boundary trace fill engine
// no dependencies; used by every other design file but btf_if
`timescale 1ns / 1ps

package btf_pkg;

  localparam int unsigned DefMaxWidth  = 256;
  localparam int unsigned DefMaxHeight = 256;
  localparam int unsigned DefColorBits = 8;

  typedef enum logic [1:0] {
    HD_RIGHT = 2'd0,
    HD_LEFT  = 2'd1,
    HD_UP    = 2'd2,
    HD_DOWN  = 2'd3
  } heading_e;

  typedef enum logic [1:0] {
    REQ_START   = 2'd0,
    REQ_REPLY   = 2'd1,
    REQ_ADVANCE = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ACT_IDLE    = 3'd0,
    ACT_REQUEST = 3'd1,
    ACT_PIXEL   = 3'd2,
    ACT_RUN     = 3'd3,
    ACT_DONE    = 3'd4
  } act_e;

  typedef enum logic [1:0] {
    CFG_X_FIRST = 2'd0,
    CFG_Y_FIRST = 2'd1,
    CFG_X_LAST  = 2'd2,
    CFG_Y_LAST  = 2'd3
  } cfg_e;

  // frame-level phase, kept between transactions
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SCAN,
    PH_WAIT_START,
    PH_TRACE,
    PH_WAIT_PROBE,
    PH_FILL
  } phase_e;

  // sequencer state within one transaction
  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_DISPATCH,
    SQ_CLEAR,
    SQ_SCAN,
    SQ_SCAN_CHK,
    SQ_PROBE,
    SQ_PROBE_CHK,
    SQ_FILL,
    SQ_FILL_CHK,
    SQ_EMIT
  } seq_e;

  typedef enum logic [2:0] {
    EM_IDLE,
    EM_DONE,
    EM_REQ_SCAN,
    EM_REQ_ORG,
    EM_REQ_NB,
    EM_PLOT_ORG,
    EM_PLOT_NB,
    EM_RUN
  } emit_e;

  typedef enum logic [1:0] {
    RD_SCAN,
    RD_PROBE,
    RD_FILL
  } rdsrc_e;

  typedef struct packed {
    logic   latch;
    logic   start;
    logic   clr_wr;
    logic   reply_org;
    logic   reply_nb;
    logic   scan_clamp;
    logic   scan_wrap;
    logic   scan_inc;
    logic   scan_found;
    logic   probe_inc;
    logic   probe_clr;
    logic   move_probe;
    logic   move_rev;
    logic   fill_init;
    logic   fill_wr;
    logic   fill_inc;
    rdsrc_e rd_src;
    logic   capture;
    emit_e  emit_kind;
    logic   emit;
  } dp_cmd_t;

  typedef struct packed {
    req_e req_type;
    logic out_busy;
    logic clr_last;
    logic scan_end;
    logic scan_lo;
    logic scan_hi;
    logic rd_known;
    logic rd_match;
    logic rc_match;
    logic k_done;
    logic nb_in_win;
    logic fallback_scan;
    logic mvp_origin;
    logic mvp_up;
    logic mvr_origin;
    logic mvr_up;
    logic fill_lap;
    logic fill_end;
    logic run_nonempty;
  } dp_stat_t;

endpackage

[design/btf_if.sv]
// channel interfaces for the boundary trace fill engine
// no dependencies
`timescale 1ns / 1ps

interface btf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] reply_color;
  modport source (output valid, req_type, reply_color, input ready);
  modport sink (input valid, req_type, reply_color, output ready);
endinterface

interface btf_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic [7:0] run_end_x;
  logic [7:0] plot_color;
  modport source (output valid, action, pos_x, pos_y, run_end_x, plot_color, input ready);
  modport sink (input valid, action, pos_x, pos_y, run_end_x, plot_color, output ready);
endinterface

interface btf_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/btf_datapath.sv]
// datapath: window registers, walker state, color store and result registers
// depends on btf_pkg; driven by btf_ctrl through dp_cmd_t
`timescale 1ns / 1ps

module btf_datapath import btf_pkg::*; #(
  parameter int unsigned MaxWidth  = DefMaxWidth,
  parameter int unsigned MaxHeight = DefMaxHeight,
  parameter int unsigned ColorBits = DefColorBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  output dp_stat_t   stat_o,
  input  logic       cfg_valid_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic [1:0] in_req_type_i,
  input  logic [7:0] in_reply_color_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [2:0] out_action_o,
  output logic [7:0] out_pos_x_o,
  output logic [7:0] out_pos_y_o,
  output logic [7:0] out_run_end_x_o,
  output logic [7:0] out_plot_color_o
);

  localparam int unsigned XW    = $clog2(MaxWidth);
  localparam int unsigned YW    = $clog2(MaxHeight);
  localparam int unsigned Depth = MaxWidth * MaxHeight;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned EW    = ColorBits + 1;

  function automatic logic [XW-1:0] col_idx(input logic [7:0] v);
    logic [20:0] r;
    r = 21'(v);
    for (int k = 7; k >= 0; k--) begin
      if (r >= (21'(MaxWidth) << k)) r = r - (21'(MaxWidth) << k);
    end
    return XW'(r);
  endfunction

  function automatic logic [YW-1:0] row_idx(input logic [7:0] v);
    logic [20:0] r;
    r = 21'(v);
    for (int k = 7; k >= 0; k--) begin
      if (r >= (21'(MaxHeight) << k)) r = r - (21'(MaxHeight) << k);
    end
    return YW'(r);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [7:0] x, input logic [7:0] y);
    return AW'(32'(row_idx(y)) * MaxWidth + 32'(col_idx(x)));
  endfunction

  // left, ahead, right of the current heading
  function automatic heading_e probe_dir(input heading_e h, input logic [1:0] k);
    heading_e d;
    d = HD_RIGHT;
    unique case (h)
      HD_RIGHT: d = (k == 2'd0) ? HD_UP : (k == 2'd1) ? HD_RIGHT : HD_DOWN;
      HD_LEFT:  d = (k == 2'd0) ? HD_DOWN : (k == 2'd1) ? HD_LEFT : HD_UP;
      HD_UP:    d = (k == 2'd0) ? HD_LEFT : (k == 2'd1) ? HD_UP : HD_RIGHT;
      HD_DOWN:  d = (k == 2'd0) ? HD_RIGHT : (k == 2'd1) ? HD_DOWN : HD_LEFT;
      default:  d = HD_RIGHT;
    endcase
    return d;
  endfunction

  function automatic heading_e reverse_dir(input heading_e h);
    heading_e d;
    d = HD_RIGHT;
    unique case (h)
      HD_RIGHT: d = HD_LEFT;
      HD_LEFT:  d = HD_RIGHT;
      HD_UP:    d = HD_DOWN;
      HD_DOWN:  d = HD_UP;
      default:  d = HD_RIGHT;
    endcase
    return d;
  endfunction

  // wrapped 8-bit step, packed as {x, y}
  function automatic logic [15:0] step_pos(input logic [7:0] x, input logic [7:0] y,
                                           input heading_e d);
    logic [7:0] nx;
    logic [7:0] ny;
    nx = x;
    ny = y;
    unique case (d)
      HD_RIGHT: nx = x + 8'd1;
      HD_LEFT:  nx = x - 8'd1;
      HD_UP:    ny = y - 8'd1;
      HD_DOWN:  ny = y + 8'd1;
      default:  nx = x;
    endcase
    return {nx, ny};
  endfunction

  function automatic logic [7:0] color8(input logic [ColorBits-1:0] c);
    logic [15:0] w;
    w = 16'(c);
    return w[7:0];
  endfunction

  logic [7:0] x_first_q, y_first_q, x_last_q, y_last_q;
  req_e       req_q;
  logic [ColorBits-1:0] rc_q, region_q;
  logic [8:0] scan_x_q, scan_y_q;
  logic [7:0] walk_x_q, walk_y_q, origin_x_q, origin_y_q;
  heading_e   heading_q;
  logic       fill_lap_q;
  logic [1:0] probe_q;
  logic [8:0] cur_q;
  logic [AW-1:0] clr_q;

  logic [EW-1:0] store_q [Depth];
  logic [EW-1:0] rdata_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata;

  logic       res_valid_q;
  act_e       res_act_q, out_act_q, res_act_d;
  logic [7:0] res_x_q, res_y_q, res_ex_q, res_c_q;
  logic [7:0] res_x_d, res_y_d, res_ex_d, res_c_d;
  logic [7:0] out_x_q, out_y_q, out_ex_q, out_c_q;

  heading_e   dir_p, dir_r;
  logic [9:0] nb_x, nb_y;
  logic [15:0] mvp, mvr;
  logic [8:0] first;
  logic [ColorBits-1:0] rc_in;
  logic [15:0] rc_wide;

  assign dir_p = probe_dir(heading_q, probe_q);
  assign dir_r = reverse_dir(heading_q);
  assign mvp   = step_pos(walk_x_q, walk_y_q, dir_p);
  assign mvr   = step_pos(walk_x_q, walk_y_q, dir_r);
  assign first = {1'b0, walk_x_q} + 9'd1;
  assign rc_wide = 16'(in_reply_color_i);
  assign rc_in   = rc_wide[ColorBits-1:0];

  // unwrapped neighbor, so that -1 and 256 fall outside the window
  always_comb begin
    nb_x = {2'b00, walk_x_q};
    nb_y = {2'b00, walk_y_q};
    unique case (dir_p)
      HD_RIGHT: nb_x = nb_x + 10'd1;
      HD_LEFT:  nb_x = nb_x - 10'd1;
      HD_UP:    nb_y = nb_y - 10'd1;
      default:  nb_y = nb_y + 10'd1;
    endcase
  end

  always_comb begin
    stat_o.req_type      = req_q;
    stat_o.out_busy      = res_valid_q && !out_ready_i;
    stat_o.clr_last      = clr_q == AW'(Depth - 1);
    stat_o.scan_end      = (scan_y_q > {1'b0, y_last_q}) || (x_first_q > x_last_q);
    stat_o.scan_lo       = scan_x_q < {1'b0, x_first_q};
    stat_o.scan_hi       = scan_x_q > {1'b0, x_last_q};
    stat_o.rd_known      = rdata_q[ColorBits];
    stat_o.rd_match      = rdata_q[ColorBits-1:0] == region_q;
    stat_o.rc_match      = rc_q == region_q;
    stat_o.k_done        = probe_q == 2'd3;
    stat_o.nb_in_win     = (nb_x >= {2'b00, x_first_q}) && (nb_x <= {2'b00, x_last_q}) &&
                           (nb_y >= {2'b00, y_first_q}) && (nb_y <= {2'b00, y_last_q});
    stat_o.fallback_scan = (heading_q == HD_RIGHT) && (walk_x_q == origin_x_q) &&
                           (walk_y_q == origin_y_q);
    stat_o.mvp_origin    = mvp == {origin_x_q, origin_y_q};
    stat_o.mvp_up        = dir_p == HD_UP;
    stat_o.mvr_origin    = mvr == {origin_x_q, origin_y_q};
    stat_o.mvr_up        = dir_r == HD_UP;
    stat_o.fill_lap      = fill_lap_q;
    stat_o.fill_end      = cur_q > {1'b0, x_last_q};
    stat_o.run_nonempty  = cur_q > first;
  end

  // store ports
  always_comb begin
    we    = cmd_i.clr_wr || cmd_i.reply_org || cmd_i.reply_nb || cmd_i.fill_wr;
    waddr = clr_q;
    wdata = '0;
    if (cmd_i.reply_org) begin
      waddr = addr_of(origin_x_q, origin_y_q);
      wdata = {1'b1, rc_q};
    end else if (cmd_i.reply_nb) begin
      waddr = addr_of(nb_x[7:0], nb_y[7:0]);
      wdata = {1'b1, rc_q};
    end else if (cmd_i.fill_wr) begin
      waddr = addr_of(cur_q[7:0], walk_y_q);
      wdata = {1'b1, region_q};
    end
    unique case (cmd_i.rd_src)
      RD_PROBE: raddr = addr_of(nb_x[7:0], nb_y[7:0]);
      RD_FILL:  raddr = addr_of(cur_q[7:0], walk_y_q);
      default:  raddr = addr_of(scan_x_q[7:0], scan_y_q[7:0]);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) store_q[waddr] <= wdata;
    rdata_q <= store_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_first_q  <= 8'd0;
      y_first_q  <= 8'd0;
      x_last_q   <= 8'd255;
      y_last_q   <= 8'd255;
      req_q      <= REQ_UNUSED;
      scan_x_q   <= 9'd0;
      scan_y_q   <= 9'd0;
      walk_x_q   <= 8'd0;
      walk_y_q   <= 8'd0;
      origin_x_q <= 8'd0;
      origin_y_q <= 8'd0;
      heading_q  <= HD_RIGHT;
      fill_lap_q <= 1'b0;
      probe_q    <= 2'd0;
      region_q   <= '0;
      cur_q      <= 9'd0;
      clr_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_e'(cfg_index_i))
          CFG_X_FIRST: x_first_q <= cfg_data_i;
          CFG_Y_FIRST: y_first_q <= cfg_data_i;
          CFG_X_LAST:  x_last_q  <= cfg_data_i;
          CFG_Y_LAST:  y_last_q  <= cfg_data_i;
          default:     x_first_q <= x_first_q;
        endcase
      end
      if (cmd_i.latch) req_q <= req_e'(in_req_type_i);
      if (cmd_i.start) begin
        clr_q      <= '0;
        scan_x_q   <= {1'b0, x_first_q};
        scan_y_q   <= {1'b0, y_first_q};
        fill_lap_q <= 1'b0;
        heading_q  <= HD_RIGHT;
        probe_q    <= 2'd0;
      end
      if (cmd_i.clr_wr) clr_q <= clr_q + AW'(1);
      if (cmd_i.reply_org) begin
        region_q   <= rc_q;
        fill_lap_q <= 1'b0;
        heading_q  <= HD_RIGHT;
        probe_q    <= 2'd0;
      end
      if (cmd_i.scan_clamp) scan_x_q <= {1'b0, x_first_q};
      if (cmd_i.scan_wrap) begin
        scan_x_q <= {1'b0, x_first_q};
        scan_y_q <= scan_y_q + 9'd1;
      end
      if (cmd_i.scan_inc) scan_x_q <= scan_x_q + 9'd1;
      if (cmd_i.scan_found) begin
        origin_x_q <= scan_x_q[7:0];
        origin_y_q <= scan_y_q[7:0];
        walk_x_q   <= scan_x_q[7:0];
        walk_y_q   <= scan_y_q[7:0];
      end
      if (cmd_i.probe_inc) probe_q <= probe_q + 2'd1;
      if (cmd_i.probe_clr) probe_q <= 2'd0;
      if (cmd_i.move_probe) begin
        {walk_x_q, walk_y_q} <= mvp;
        heading_q  <= (stat_o.mvp_origin && !fill_lap_q) ? HD_RIGHT : dir_p;
        fill_lap_q <= fill_lap_q || stat_o.mvp_origin;
        probe_q    <= 2'd0;
      end
      if (cmd_i.move_rev) begin
        {walk_x_q, walk_y_q} <= mvr;
        heading_q  <= (stat_o.mvr_origin && !fill_lap_q) ? HD_RIGHT : dir_r;
        fill_lap_q <= fill_lap_q || stat_o.mvr_origin;
        probe_q    <= 2'd0;
      end
      if (cmd_i.fill_init) cur_q <= first;
      if (cmd_i.fill_inc) cur_q <= cur_q + 9'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) rc_q <= rc_in;
  end

  // staged result, then the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_comb begin
    res_act_d = ACT_IDLE;
    res_x_d   = 8'd0;
    res_y_d   = 8'd0;
    res_ex_d  = 8'd0;
    res_c_d   = 8'd0;
    unique case (cmd_i.emit_kind)
      EM_DONE: res_act_d = ACT_DONE;
      EM_REQ_SCAN: begin
        res_act_d = ACT_REQUEST;
        res_x_d   = scan_x_q[7:0];
        res_y_d   = scan_y_q[7:0];
      end
      EM_REQ_ORG: begin
        res_act_d = ACT_REQUEST;
        res_x_d   = origin_x_q;
        res_y_d   = origin_y_q;
      end
      EM_REQ_NB: begin
        res_act_d = ACT_REQUEST;
        res_x_d   = nb_x[7:0];
        res_y_d   = nb_y[7:0];
      end
      EM_PLOT_ORG: begin
        res_act_d = ACT_PIXEL;
        res_x_d   = origin_x_q;
        res_y_d   = origin_y_q;
        res_c_d   = color8(rc_q);
      end
      EM_PLOT_NB: begin
        res_act_d = ACT_PIXEL;
        res_x_d   = nb_x[7:0];
        res_y_d   = nb_y[7:0];
        res_c_d   = color8(rc_q);
      end
      EM_RUN: begin
        res_act_d = ACT_RUN;
        res_x_d   = first[7:0];
        res_y_d   = walk_y_q;
        res_ex_d  = cur_q[7:0] - 8'd1;
        res_c_d   = color8(region_q);
      end
      default: res_act_d = ACT_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      res_act_q <= res_act_d;
      res_x_q   <= res_x_d;
      res_y_q   <= res_y_d;
      res_ex_q  <= res_ex_d;
      res_c_q   <= res_c_d;
    end
    if (cmd_i.emit) begin
      out_act_q <= res_act_q;
      out_x_q   <= res_x_q;
      out_y_q   <= res_y_q;
      out_ex_q  <= res_ex_q;
      out_c_q   <= res_c_q;
    end
  end

  assign out_valid_o      = res_valid_q;
  assign out_action_o     = out_act_q;
  assign out_pos_x_o      = out_x_q;
  assign out_pos_y_o      = out_y_q;
  assign out_run_end_x_o  = out_ex_q;
  assign out_plot_color_o = out_c_q;

endmodule

[design/btf_ctrl.sv]
// controller: frame phase and per-transaction sequencer
// depends on btf_pkg; drives btf_datapath through dp_cmd_t
`timescale 1ns / 1ps

module btf_ctrl import btf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  seq_e   seq_q, seq_d;
  phase_e phase_q, phase_d;

  function automatic phase_e after_move(input logic at_origin, input logic up,
                                        input logic lap);
    phase_e p;
    if (at_origin) p = lap ? PH_SCAN : PH_TRACE;
    else if (lap && up) p = PH_FILL;
    else p = PH_TRACE;
    return p;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= SQ_IDLE;
      phase_q <= PH_IDLE;
    end else begin
      seq_q   <= seq_d;
      phase_q <= phase_d;
    end
  end

  assign in_ready_o = seq_q == SQ_IDLE;

  always_comb begin
    cmd_o   = '0;
    seq_d   = seq_q;
    phase_d = phase_q;
    unique case (seq_q)
      SQ_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          seq_d = SQ_DISPATCH;
        end
      end
      SQ_DISPATCH: begin
        seq_d = SQ_EMIT;
        cmd_o.capture = 1'b1;
        cmd_o.emit_kind = EM_IDLE;
        unique case (stat_i.req_type)
          REQ_START: begin
            cmd_o.start = 1'b1;
            phase_d = PH_SCAN;
            seq_d = SQ_CLEAR;
          end
          REQ_REPLY: begin
            if (phase_q == PH_WAIT_START) begin
              cmd_o.reply_org = 1'b1;
              cmd_o.emit_kind = EM_PLOT_ORG;
              phase_d = PH_TRACE;
            end else if (phase_q == PH_WAIT_PROBE) begin
              cmd_o.reply_nb = 1'b1;
              cmd_o.emit_kind = EM_PLOT_NB;
              if (stat_i.rc_match) begin
                cmd_o.move_probe = 1'b1;
                phase_d = after_move(stat_i.mvp_origin, stat_i.mvp_up, stat_i.fill_lap);
              end else begin
                cmd_o.probe_inc = 1'b1;
                phase_d = PH_TRACE;
              end
            end
          end
          REQ_ADVANCE: begin
            unique case (phase_q)
              PH_SCAN: begin
                cmd_o.capture = 1'b0;
                seq_d = SQ_SCAN;
              end
              PH_WAIT_START: cmd_o.emit_kind = EM_REQ_ORG;
              PH_WAIT_PROBE: cmd_o.emit_kind = EM_REQ_NB;
              PH_TRACE: begin
                cmd_o.capture = 1'b0;
                seq_d = SQ_PROBE;
              end
              PH_FILL: begin
                cmd_o.capture = 1'b0;
                cmd_o.fill_init = 1'b1;
                seq_d = SQ_FILL;
              end
              default: cmd_o.emit_kind = EM_IDLE;
            endcase
          end
          default: cmd_o.emit_kind = EM_IDLE;
        endcase
      end
      SQ_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) seq_d = SQ_EMIT;
      end
      SQ_SCAN: begin
        cmd_o.rd_src = RD_SCAN;
        if (stat_i.scan_end) begin
          cmd_o.capture = 1'b1;
          cmd_o.emit_kind = EM_DONE;
          phase_d = PH_IDLE;
          seq_d = SQ_EMIT;
        end else if (stat_i.scan_lo) begin
          cmd_o.scan_clamp = 1'b1;
        end else if (stat_i.scan_hi) begin
          cmd_o.scan_wrap = 1'b1;
        end else begin
          seq_d = SQ_SCAN_CHK;
        end
      end
      SQ_SCAN_CHK: begin
        if (!stat_i.rd_known) begin
          cmd_o.scan_found = 1'b1;
          cmd_o.capture = 1'b1;
          cmd_o.emit_kind = EM_REQ_SCAN;
          phase_d = PH_WAIT_START;
          seq_d = SQ_EMIT;
        end else begin
          cmd_o.scan_inc = 1'b1;
          seq_d = SQ_SCAN;
        end
      end
      SQ_PROBE: begin
        cmd_o.rd_src = RD_PROBE;
        if (stat_i.k_done) begin
          // all three probes failed: back out, or the trace is a single pixel
          cmd_o.capture = 1'b1;
          cmd_o.emit_kind = EM_IDLE;
          seq_d = SQ_EMIT;
          if (stat_i.fallback_scan) begin
            phase_d = PH_SCAN;
          end else begin
            cmd_o.move_rev = 1'b1;
            phase_d = after_move(stat_i.mvr_origin, stat_i.mvr_up, stat_i.fill_lap);
          end
        end else if (!stat_i.nb_in_win) begin
          cmd_o.probe_inc = 1'b1;
        end else begin
          seq_d = SQ_PROBE_CHK;
        end
      end
      SQ_PROBE_CHK: begin
        if (!stat_i.rd_known) begin
          cmd_o.capture = 1'b1;
          cmd_o.emit_kind = EM_REQ_NB;
          phase_d = PH_WAIT_PROBE;
          seq_d = SQ_EMIT;
        end else if (stat_i.rd_match) begin
          cmd_o.move_probe = 1'b1;
          cmd_o.capture = 1'b1;
          cmd_o.emit_kind = EM_IDLE;
          phase_d = after_move(stat_i.mvp_origin, stat_i.mvp_up, stat_i.fill_lap);
          seq_d = SQ_EMIT;
        end else begin
          cmd_o.probe_inc = 1'b1;
          seq_d = SQ_PROBE;
        end
      end
      SQ_FILL: begin
        cmd_o.rd_src = RD_FILL;
        if (stat_i.fill_end) begin
          cmd_o.probe_clr = 1'b1;
          cmd_o.capture = 1'b1;
          cmd_o.emit_kind = stat_i.run_nonempty ? EM_RUN : EM_IDLE;
          phase_d = PH_TRACE;
          seq_d = SQ_EMIT;
        end else begin
          seq_d = SQ_FILL_CHK;
        end
      end
      SQ_FILL_CHK: begin
        if (!stat_i.rd_known) begin
          cmd_o.fill_wr = 1'b1;
          cmd_o.fill_inc = 1'b1;
          seq_d = SQ_FILL;
        end else if (stat_i.rd_match) begin
          cmd_o.fill_inc = 1'b1;
          seq_d = SQ_FILL;
        end else begin
          // run stops at a pixel of another color
          cmd_o.probe_clr = 1'b1;
          cmd_o.capture = 1'b1;
          cmd_o.emit_kind = stat_i.run_nonempty ? EM_RUN : EM_IDLE;
          phase_d = PH_TRACE;
          seq_d = SQ_EMIT;
        end
      end
      SQ_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          seq_d = SQ_IDLE;
        end
      end
      default: seq_d = SQ_IDLE;
    endcase
  end

endmodule

[design/boundary_trace_fill_unit.sv]
// boundary trace fill engine, top level: one result per input transaction.
// a reply, a reissued request or an ignored input passes SQ_DISPATCH and SQ_EMIT;
// the next input is taken once the last result is emitted; a scan checks each pixel in
// SQ_SCAN and SQ_SCAN_CHK, a trace probe in SQ_PROBE and SQ_PROBE_CHK, a fill pixel in
// SQ_FILL and SQ_FILL_CHK. a start runs a clearing pass over the whole color store.
// reset clears control state; store contents are undefined until a start clears them
`timescale 1ns / 1ps

module boundary_trace_fill_unit import btf_pkg::*; #(
  parameter int unsigned MaxWidth  = DefMaxWidth,
  parameter int unsigned MaxHeight = DefMaxHeight,
  parameter int unsigned ColorBits = DefColorBits
) (
  input logic            clk_i,
  input logic            rst_ni,
  btf_in_if.sink         in_i,
  btf_out_if.source      out_o,
  btf_cfg_if.sink        cfg_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_i.ready = 1'b1;

  btf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  btf_datapath #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight),
    .ColorBits (ColorBits)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_valid_i      (cfg_i.valid),
    .cfg_index_i      (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .in_req_type_i    (in_i.req_type),
    .in_reply_color_i (in_i.reply_color),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .out_action_o     (out_o.action),
    .out_pos_x_o      (out_o.pos_x),
    .out_pos_y_o      (out_o.pos_y),
    .out_run_end_x_o  (out_o.run_end_x),
    .out_plot_color_o (out_o.plot_color)
  );

  // sequencer is busy right after taking a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken while a transaction is in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.action <= ACT_DONE)
    else $error("action code out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.action == ACT_RUN |-> out_o.run_end_x >= out_o.pos_x)
    else $error("fill run ends before it starts");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.action == ACT_IDLE || out_o.action == ACT_DONE) |->
      out_o.pos_x == 8'd0 && out_o.pos_y == 8'd0 && out_o.plot_color == 8'd0)
    else $error("idle or done result carries payload");

endmodule

[tb/sv/boundary_trace_fill_unit_tb.sv]
// testbench for boundary_trace_fill_unit: drives start, reply and advance requests,
// answers color requests from a random picture and checks every action against
// its own model of the engine. depends on btf_pkg and the channel interfaces
`timescale 1ns / 1ps

module boundary_trace_fill_unit_tb;
  import btf_pkg::*;

  typedef struct packed {
    act_e     action;
    bit [7:0] pos_x;
    bit [7:0] pos_y;
    bit [7:0] run_end_x;
    bit [7:0] plot_color;
  } action_t;

  logic clk = 1'b0;
  logic rst_n;

  btf_in_if  in_if ();
  btf_out_if out_if ();
  btf_cfg_if cfg_if ();

  boundary_trace_fill_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // engine model state
  bit [8:0] color_mem [0:65535];
  bit [7:0] x_lo, y_lo, x_hi, y_hi;
  bit [7:0] scan_x, scan_y, walk_x, walk_y, org_x, org_y, region, run_cur;
  heading_e hd;
  bit       second_lap;
  phase_e   ph;
  bit [1:0] probe_k;

  // host picture and run control
  bit [7:0] picture [0:65535];
  action_t  pending_actions [$];
  int       errors = 0;
  int       items_sent = 0;
  int       hold_cycles = 0;
  bit       calm = 1'b0;
  int       noise_pct = 0;

  function automatic int dx_of(heading_e d);
    case (d)
      HD_RIGHT: return 1;
      HD_LEFT:  return -1;
      default:  return 0;
    endcase
  endfunction

  function automatic int dy_of(heading_e d);
    case (d)
      HD_UP:   return -1;
      HD_DOWN: return 1;
      default: return 0;
    endcase
  endfunction

  // heading after taking the left, ahead or right probe
  function automatic heading_e turn_of(heading_e h, int k);
    case (h)
      HD_RIGHT: return (k == 0) ? HD_UP : (k == 1) ? HD_RIGHT : HD_DOWN;
      HD_LEFT:  return (k == 0) ? HD_DOWN : (k == 1) ? HD_LEFT : HD_UP;
      HD_UP:    return (k == 0) ? HD_LEFT : (k == 1) ? HD_UP : HD_RIGHT;
      default:  return (k == 0) ? HD_RIGHT : (k == 1) ? HD_DOWN : HD_LEFT;
    endcase
  endfunction

  function automatic heading_e reverse_of(heading_e h);
    case (h)
      HD_RIGHT: return HD_LEFT;
      HD_LEFT:  return HD_RIGHT;
      HD_UP:    return HD_DOWN;
      default:  return HD_UP;
    endcase
  endfunction

  function automatic int addr(int x, int y);
    return ((y & 255) << 8) | (x & 255);
  endfunction

  function automatic bit in_win(int x, int y);
    return x >= x_lo && x <= x_hi && y >= y_lo && y <= y_hi;
  endfunction

  function automatic action_t mk(act_e a, int x, int y, int ex, int c);
    action_t r;
    r.action = a;
    r.pos_x = x[7:0];
    r.pos_y = y[7:0];
    r.run_end_x = ex[7:0];
    r.plot_color = c[7:0];
    return r;
  endfunction

  function automatic void move_to(heading_e d);
    walk_x = 8'(walk_x + dx_of(d));
    walk_y = 8'(walk_y + dy_of(d));
    hd = d;
    probe_k = 2'd0;
    if (walk_x == org_x && walk_y == org_y) begin
      if (second_lap) begin
        ph = PH_SCAN;
      end else begin
        second_lap = 1'b1;
        hd = HD_RIGHT;
        ph = PH_TRACE;
      end
    end else if (second_lap && hd == HD_UP) begin
      ph = PH_FILL;
    end else begin
      ph = PH_TRACE;
    end
  endfunction

  function automatic action_t scan_step();
    int x;
    int y;
    x = scan_x;
    y = scan_y;
    while (y <= y_hi && x_lo <= x_hi) begin
      if (x < x_lo) x = x_lo;
      if (x > x_hi) begin
        x = x_lo;
        y++;
        continue;
      end
      if (!color_mem[addr(x, y)][8]) begin
        scan_x = 8'(x);
        scan_y = 8'(y);
        org_x = 8'(x);
        org_y = 8'(y);
        walk_x = 8'(x);
        walk_y = 8'(y);
        ph = PH_WAIT_START;
        return mk(ACT_REQUEST, x, y, 0, 0);
      end
      x++;
    end
    ph = PH_IDLE;
    return mk(ACT_DONE, 0, 0, 0, 0);
  endfunction

  function automatic action_t trace_step();
    heading_e d;
    int nx;
    int ny;
    bit [8:0] e;
    for (int k = probe_k; k < 3; k++) begin
      d = turn_of(hd, k);
      nx = walk_x + dx_of(d);
      ny = walk_y + dy_of(d);
      if (!in_win(nx, ny)) continue;
      e = color_mem[addr(nx, ny)];
      if (!e[8]) begin
        probe_k = 2'(k);
        ph = PH_WAIT_PROBE;
        return mk(ACT_REQUEST, nx, ny, 0, 0);
      end
      if (e[7:0] == region) begin
        move_to(d);
        return mk(ACT_IDLE, 0, 0, 0, 0);
      end
    end
    if (hd == HD_RIGHT && walk_x == org_x && walk_y == org_y) ph = PH_SCAN;
    else move_to(reverse_of(hd));
    return mk(ACT_IDLE, 0, 0, 0, 0);
  endfunction

  function automatic action_t fill_step();
    int first;
    int cur;
    int a;
    first = walk_x + 1;
    cur = first;
    while (cur <= x_hi) begin
      a = addr(cur, walk_y);
      if (!color_mem[a][8]) color_mem[a] = {1'b1, region};
      else if (color_mem[a][7:0] != region) break;
      cur++;
    end
    run_cur = 8'(cur - 1);
    ph = PH_TRACE;
    probe_k = 2'd0;
    if (cur - 1 >= first) return mk(ACT_RUN, first, walk_y, cur - 1, region);
    return mk(ACT_IDLE, 0, 0, 0, 0);
  endfunction

  function automatic heading_e probe_dir();
    return turn_of(hd, (probe_k < 3) ? probe_k : 2);
  endfunction

  function automatic action_t engine_step(req_e req, bit [7:0] rc);
    heading_e d;
    int nx;
    int ny;
    case (req)
      REQ_START: begin
        foreach (color_mem[i]) color_mem[i] = '0;
        scan_x = x_lo;
        scan_y = y_lo;
        second_lap = 1'b0;
        hd = HD_RIGHT;
        probe_k = 2'd0;
        ph = PH_SCAN;
        return mk(ACT_IDLE, 0, 0, 0, 0);
      end
      REQ_REPLY: begin
        if (ph == PH_WAIT_START) begin
          region = rc;
          color_mem[addr(org_x, org_y)] = {1'b1, rc};
          second_lap = 1'b0;
          hd = HD_RIGHT;
          probe_k = 2'd0;
          ph = PH_TRACE;
          return mk(ACT_PIXEL, org_x, org_y, 0, rc);
        end else if (ph == PH_WAIT_PROBE) begin
          d = probe_dir();
          nx = walk_x + dx_of(d);
          ny = walk_y + dy_of(d);
          color_mem[addr(nx, ny)] = {1'b1, rc};
          if (rc == region) begin
            move_to(d);
          end else begin
            probe_k = probe_k + 2'd1;
            ph = PH_TRACE;
          end
          return mk(ACT_PIXEL, nx, ny, 0, rc);
        end
        return mk(ACT_IDLE, 0, 0, 0, 0);
      end
      REQ_ADVANCE: begin
        case (ph)
          PH_SCAN:       return scan_step();
          PH_WAIT_START: return mk(ACT_REQUEST, org_x, org_y, 0, 0);
          PH_WAIT_PROBE: begin
            d = probe_dir();
            return mk(ACT_REQUEST, walk_x + dx_of(d), walk_y + dy_of(d), 0, 0);
          end
          PH_TRACE:      return trace_step();
          PH_FILL:       return fill_step();
          default:       return mk(ACT_IDLE, 0, 0, 0, 0);
        endcase
      end
      default: return mk(ACT_IDLE, 0, 0, 0, 0);
    endcase
  endfunction

  // color the host answers for the pixel now being asked for
  function automatic bit [7:0] host_color();
    heading_e d;
    if (ph == PH_WAIT_START) return picture[addr(org_x, org_y)];
    d = probe_dir();
    return picture[addr(walk_x + dx_of(d), walk_y + dy_of(d))];
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  task automatic send_item(req_e req, bit [7:0] rc);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.req_type <= req;
    in_if.reply_color <= rc;
    do @(posedge clk); while (!in_if.ready);
    pending_actions.push_back(engine_step(req, rc));
    items_sent++;
  endtask

  // stop offering and wait until every action is back, then let the engine settle
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_actions.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_e idx, bit [7:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_X_FIRST: x_lo = value;
      CFG_Y_FIRST: y_lo = value;
      CFG_X_LAST:  x_hi = value;
      default:     y_hi = value;
    endcase
    @(posedge clk);
  endtask

  task automatic set_window(bit [7:0] xf, bit [7:0] yf, bit [7:0] xl, bit [7:0] yl);
    write_reg(CFG_X_FIRST, xf);
    write_reg(CFG_Y_FIRST, yf);
    write_reg(CFG_X_LAST, xl);
    write_reg(CFG_Y_LAST, yl);
  endtask

  task automatic paint(bit [7:0] c0, bit [7:0] c1, bit [7:0] c2, int colors);
    int pick;
    foreach (picture[i]) begin
      pick = $urandom_range(0, colors - 1);
      picture[i] = (pick == 0) ? c0 : (pick == 1) ? c1 : c2;
    end
  endtask

  // one frame: start, then answer requests and advance until done or out of budget;
  // a nonzero hold stalls the receiver once the clearing pass is over
  task automatic run_frame(int budget, int hold = 0);
    int n;
    int r;
    send_item(REQ_START, 8'($urandom_range(0, 255)));
    if (hold > 0) begin
      in_if.valid <= 1'b0;
      while (pending_actions.size() != 0) @(posedge clk);
      hold_cycles = hold;
    end
    n = 0;
    while (n < budget && ph != PH_IDLE) begin
      r = $urandom_range(0, 99);
      if (r < noise_pct) begin
        case ($urandom_range(0, 2))
          0:       send_item(REQ_REPLY, 8'($urandom_range(0, 255)));
          1:       send_item(REQ_ADVANCE, 8'($urandom_range(0, 255)));
          default: send_item(REQ_UNUSED, 8'($urandom_range(0, 255)));
        endcase
      end else if (ph == PH_WAIT_START || ph == PH_WAIT_PROBE) begin
        send_item(REQ_REPLY, host_color());
      end else begin
        send_item(REQ_ADVANCE, 8'($urandom_range(0, 255)));
      end
      n++;
    end
    drain();
  endtask

  task automatic test_before_start();
    send_item(REQ_ADVANCE, 8'h00);
    send_item(REQ_REPLY, 8'hff);
    send_item(REQ_UNUSED, 8'h5a);
    drain();
  endtask

  task automatic test_small_frame();
    set_window(8'd2, 8'd3, 8'd5, 8'd5);
    paint(8'h00, 8'hff, 8'h00, 2);
    run_frame(200);
  endtask

  task automatic test_empty_window();
    set_window(8'd10, 8'd0, 8'd9, 8'd255);
    send_item(REQ_START, 8'h00);
    send_item(REQ_ADVANCE, 8'h00);
    send_item(REQ_ADVANCE, 8'h00);
    send_item(REQ_REPLY, 8'h80);
    drain();
  endtask

  task automatic test_window_edges();
    set_window(8'd250, 8'd252, 8'd255, 8'd255);
    paint(8'h7f, 8'h80, 8'h01, 3);
    run_frame(300);
    set_window(8'd0, 8'd0, 8'd3, 8'd3);
    paint(8'h42, 8'h42, 8'h42, 1);
    noise_pct = 15;
    run_frame(120);
    noise_pct = 0;
  endtask

  // receiver holds off while the sender keeps pushing, then a full pause to drain
  task automatic test_backpressure();
    set_window(8'd100, 8'd40, 8'd106, 8'd45);
    paint(8'h0f, 8'hf0, 8'h33, 3);
    calm = 1'b1;
    run_frame(250, 300);
    calm = 1'b0;
  endtask

  task automatic test_random_frames();
    int w;
    int h;
    int xf;
    int yf;
    int starts;
    starts = 0;
    noise_pct = 8;
    while (items_sent < 1300 && starts < 20) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 8);
      xf = $urandom_range(0, 256 - w);
      yf = $urandom_range(0, 256 - h);
      set_window(8'(xf), 8'(yf), 8'(xf + w - 1), 8'(yf + h - 1));
      paint(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
            8'($urandom_range(0, 255)), $urandom_range(1, 3));
      calm = ($urandom_range(0, 3) == 0);
      run_frame(300);
      starts++;
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid <= 1'b0;
    in_if.req_type <= REQ_ADVANCE;
    in_if.reply_color <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_X_FIRST;
    cfg_if.data <= '0;
    x_lo = 0;
    y_lo = 0;
    x_hi = 255;
    y_hi = 255;
    scan_x = 0;
    scan_y = 0;
    walk_x = 0;
    walk_y = 0;
    org_x = 0;
    org_y = 0;
    region = 0;
    run_cur = 0;
    hd = HD_RIGHT;
    second_lap = 1'b0;
    ph = PH_IDLE;
    probe_k = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_before_start();
    test_small_frame();
    test_empty_window();
    test_window_edges();
    test_backpressure();
    test_random_frames();
    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // receiver: random stalls per transaction, plus a counted long hold on request
  initial begin
    int n;
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      n = calm ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid && hold_cycles == 0);
    end
  end

  always @(posedge clk) begin
    action_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_actions.size() == 0) begin
        report_mismatch("unexpected action", out_if.action, -1);
      end else begin
        want = pending_actions.pop_front();
        if (out_if.action !== want.action)
          report_mismatch("action", out_if.action, want.action);
        if (out_if.pos_x !== want.pos_x) report_mismatch("pos_x", out_if.pos_x, want.pos_x);
        if (out_if.pos_y !== want.pos_y) report_mismatch("pos_y", out_if.pos_y, want.pos_y);
        if (out_if.run_end_x !== want.run_end_x)
          report_mismatch("run_end_x", out_if.run_end_x, want.run_end_x);
        if (out_if.plot_color !== want.plot_color)
          report_mismatch("plot_color", out_if.plot_color, want.plot_color);
      end
    end
  end

  initial begin
    #100ms;
    $display("simulation failed");
    $finish;
  end

endmodule
